[rtl/mbrtu_pkg.sv]
`default_nettype none

package mbrtu_pkg;

    localparam int MAX_PAYLOAD_DEF = 240;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0]  SLAVE_MAX    = 8'd247;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [11:0] REPLY_WR_LEN = 12'd8;

    localparam logic [7:0] FC_RD_COILS    = 8'd1;
    localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
    localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
    localparam logic [7:0] FC_RD_INPUT    = 8'd4;
    localparam logic [7:0] FC_WR_COIL     = 8'd5;
    localparam logic [7:0] FC_WR_REG      = 8'd6;
    localparam logic [7:0] FC_WR_COILS    = 8'd15;
    localparam logic [7:0] FC_WR_REGS     = 8'd16;

    localparam logic [1:0] AREA_COILS    = 2'd0;
    localparam logic [1:0] AREA_DISCRETE = 2'd1;
    localparam logic [1:0] AREA_INPUT    = 2'd2;
    localparam logic [1:0] AREA_HOLDING  = 2'd3;

    localparam int CMD_BYTES = 7;

    // one unit of work for the back end
    typedef struct packed {
        logic                          init;
        logic                          err;
        logic                          fin;
        logic [2:0]                    nbytes;
        logic [11:0]                   rlen;
        logic [CMD_BYTES-1:0][7:0]     bytes;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/modbus_rtu_request_framer.sv]
`default_nettype none

// Modbus RTU request framer. A header transaction (kind 0) is classified combinationally
// and its frame is eight bytes for a read (slave, function, address, count, CRC low,
// CRC high), four for a single write, seven for a multiple write, or one error result.
// Write payload transactions (kind 1) follow; the last one adds the two CRC bytes. The
// input side takes a transaction in every cycle while the two-entry command queue has
// room, so throughput is set by the output, one byte per cycle while the receiver is
// ready, with the CRC advanced by one byte in the same cycle. expected_len is shown with
// the final CRC byte; a rejected header gives a single result with param_error set.
module modbus_rtu_request_framer #(
    parameter int MAX_PAYLOAD = mbrtu_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_kind,
    input  wire logic [7:0]   i_slave,
    input  wire logic         i_is_write,
    input  wire logic [1:0]   i_area,
    input  wire logic [15:0]  i_start_addr,
    input  wire logic [15:0]  i_item_count,
    input  wire logic [7:0]   i_data_byte,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [7:0]        o_frame_byte,
    output logic              o_last,
    output logic [11:0]       o_expected_len,
    output logic              o_param_error
);
    import mbrtu_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    mbrtu_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_slave      (i_slave),
        .i_is_write   (i_is_write),
        .i_area       (i_area),
        .i_start_addr (i_start_addr),
        .i_item_count (i_item_count),
        .i_data_byte  (i_data_byte),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    mbrtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    mbrtu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_cmd          (w_head_cmd),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_last         (o_last),
        .o_expected_len (o_expected_len),
        .o_param_error  (o_param_error)
    );

endmodule

`default_nettype wire

[rtl/mbrtu_front.sv]
`default_nettype none

module mbrtu_front #(
    parameter int MAX_PAYLOAD = mbrtu_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_kind,
    input  wire logic [7:0]       i_slave,
    input  wire logic             i_is_write,
    input  wire logic [1:0]       i_area,
    input  wire logic [15:0]      i_start_addr,
    input  wire logic [15:0]      i_item_count,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output mbrtu_pkg::t_cmd       o_cmd
);
    import mbrtu_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_COIL = 2'd2;

    localparam logic [16:0] CNT_LIMIT = 17'(8 * MAX_PAYLOAD);
    localparam logic [16:0] PAY_LIMIT = 17'(MAX_PAYLOAD);

    logic [1:0]  r_mode, n_mode;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_mask, n_mask;
    logic [11:0] r_rlen, n_rlen;

    logic        w_accept;
    logic [16:0] w_cnt;
    logic [16:0] w_coil_bytes;
    logic [16:0] w_reg_bytes;
    logic        w_err;
    logic [7:0]  w_fc;
    logic [7:0]  w_nbytes;

    assign o_in_ready   = !i_q_full;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_cnt        = {1'b0, i_item_count};
    assign w_coil_bytes = (w_cnt + 17'd7) >> 3;
    assign w_reg_bytes  = {i_item_count, 1'b0};

    // header classification
    always_comb begin
        w_err    = (i_slave > SLAVE_MAX) || (w_cnt == 17'd0) || (w_cnt > CNT_LIMIT);
        w_fc     = FC_RD_COILS;
        w_nbytes = 8'd0;
        if (!i_is_write) begin
            unique case (i_area)
                AREA_COILS:    w_fc = FC_RD_COILS;
                AREA_DISCRETE: w_fc = FC_RD_DISCRETE;
                AREA_INPUT:    w_fc = FC_RD_INPUT;
                AREA_HOLDING:  w_fc = FC_RD_HOLDING;
                default:       w_fc = FC_RD_COILS;
            endcase
        end else if (i_area == AREA_COILS) begin
            w_fc     = (w_cnt == 17'd1) ? FC_WR_COIL : FC_WR_COILS;
            w_nbytes = w_coil_bytes[7:0];
            if (w_fc == FC_WR_COILS && w_coil_bytes > PAY_LIMIT) begin
                w_err = 1'b1;
            end
        end else if (i_area == AREA_HOLDING) begin
            w_fc     = (w_cnt == 17'd1) ? FC_WR_REG : FC_WR_REGS;
            w_nbytes = w_reg_bytes[7:0];
            if (w_fc == FC_WR_REGS && w_reg_bytes > PAY_LIMIT) begin
                w_err = 1'b1;
            end
        end else begin
            w_err = 1'b1;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_left = r_left;
        n_mask = r_mask;
        n_rlen = r_rlen;
        o_push = 1'b0;
        o_cmd  = '0;
        o_cmd.rlen = r_rlen;
        if (w_accept) begin
            if (!i_kind) begin
                n_mode = MODE_IDLE;
                n_left = 8'd0;
                n_mask = 8'hFF;
                o_push = 1'b1;
                o_cmd.init = 1'b1;
                o_cmd.bytes[0] = i_slave;
                o_cmd.bytes[1] = w_fc;
                o_cmd.bytes[2] = i_start_addr[15:8];
                o_cmd.bytes[3] = i_start_addr[7:0];
                o_cmd.bytes[4] = i_item_count[15:8];
                o_cmd.bytes[5] = i_item_count[7:0];
                o_cmd.bytes[6] = w_nbytes;
                if (w_err) begin
                    n_rlen       = 12'd0;
                    o_cmd.err    = 1'b1;
                    o_cmd.bytes  = '0;
                end else if (!i_is_write) begin
                    n_rlen       = (i_area == AREA_COILS || i_area == AREA_DISCRETE)
                                   ? 12'(w_coil_bytes + 17'd5) : 12'(w_reg_bytes + 17'd5);
                    o_cmd.nbytes = 3'd6;
                    o_cmd.fin    = 1'b1;
                end else if (w_fc == FC_WR_COIL) begin
                    n_rlen       = REPLY_WR_LEN;
                    n_mode       = MODE_COIL;
                    n_left       = 8'd1;
                    o_cmd.nbytes = 3'd4;
                end else if (w_fc == FC_WR_REG) begin
                    n_rlen       = REPLY_WR_LEN;
                    n_mode       = MODE_DATA;
                    n_left       = 8'd2;
                    o_cmd.nbytes = 3'd4;
                end else begin
                    n_rlen       = REPLY_WR_LEN;
                    n_mode       = MODE_DATA;
                    n_left       = w_nbytes;
                    o_cmd.nbytes = 3'd7;
                    if (w_fc == FC_WR_COILS && i_item_count[2:0] != 3'd0) begin
                        n_mask = 8'((9'd1 << i_item_count[2:0]) - 9'd1);
                    end
                end
                o_cmd.rlen = n_rlen;
            end else begin
                unique case (r_mode)
                    MODE_COIL: begin
                        o_push         = 1'b1;
                        o_cmd.bytes[0] = i_data_byte[0] ? 8'hFF : 8'h00;
                        o_cmd.bytes[1] = 8'h00;
                        o_cmd.nbytes   = 3'd2;
                        o_cmd.fin      = 1'b1;
                        n_mode         = MODE_IDLE;
                        n_left         = 8'd0;
                        n_mask         = 8'hFF;
                    end
                    MODE_DATA: begin
                        o_push       = 1'b1;
                        o_cmd.nbytes = 3'd1;
                        if (r_left <= 8'd1) begin
                            o_cmd.bytes[0] = i_data_byte & r_mask;
                            o_cmd.fin      = 1'b1;
                            n_mode         = MODE_IDLE;
                            n_left         = 8'd0;
                            n_mask         = 8'hFF;
                        end else begin
                            o_cmd.bytes[0] = i_data_byte;
                            n_left         = r_left - 8'd1;
                        end
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_left <= 8'd0;
            r_mask <= 8'hFF;
            r_rlen <= 12'd0;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_mask <= n_mask;
            r_rlen <= n_rlen;
        end
    end

endmodule

`default_nettype wire

[rtl/mbrtu_queue.sv]
`default_nettype none

module mbrtu_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mbrtu_pkg::t_cmd  i_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output mbrtu_pkg::t_cmd       o_cmd
);
    import mbrtu_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/mbrtu_back.sv]
`default_nettype none

module mbrtu_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire mbrtu_pkg::t_cmd  i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_frame_byte,
    output logic                  o_last,
    output logic [11:0]           o_expected_len,
    output logic                  o_param_error
);
    import mbrtu_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_pos;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [11:0] r_rlen;
    logic        r_err;

    logic        w_adv;
    logic [3:0]  w_total;
    logic        w_final;
    logic [15:0] w_base;
    logic [7:0]  w_byte;
    logic        w_last;
    logic [11:0] w_rlen;
    logic        w_err;

    assign w_adv   = !i_empty && (!r_ov || i_out_ready);
    assign w_total = {1'b0, i_cmd.nbytes} + (i_cmd.fin ? 4'd2 : 4'd0);
    assign w_final = i_cmd.err || (r_pos == w_total - 4'd1);
    assign w_base  = (r_pos == 4'd0 && i_cmd.init) ? CRC_INIT : r_crc;
    assign o_pop   = w_adv && w_final;

    // one frame byte per step, crc trails the data bytes
    always_comb begin
        w_byte = 8'h00;
        w_last = 1'b0;
        w_rlen = 12'd0;
        w_err  = 1'b0;
        n_crc  = r_crc;
        if (i_cmd.err) begin
            w_last = 1'b1;
            w_err  = 1'b1;
            n_crc  = CRC_INIT;
        end else if (r_pos < {1'b0, i_cmd.nbytes}) begin
            w_byte = i_cmd.bytes[r_pos[2:0]];
            n_crc  = crc_byte(w_base, w_byte);
        end else if (r_pos == {1'b0, i_cmd.nbytes}) begin
            w_byte = w_base[7:0];
            n_crc  = w_base;
        end else begin
            w_byte = w_base[15:8];
            w_last = 1'b1;
            w_rlen = i_cmd.rlen;
            n_crc  = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_pos <= 4'd0;
            r_ov  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_crc <= n_crc;
                r_pos <= w_final ? 4'd0 : r_pos + 4'd1;
                r_ov  <= 1'b1;
            end else if (i_out_ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_byte <= w_byte;
            r_last <= w_last;
            r_rlen <= w_rlen;
            r_err  <= w_err;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_frame_byte   = r_byte;
    assign o_last         = r_last;
    assign o_expected_len = r_rlen;
    assign o_param_error  = r_err;

endmodule

`default_nettype wire

[rtl/mbrtu_checker.sv]
`default_nettype none

module mbrtu_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_out_valid,
    input wire logic         i_out_ready,
    input wire logic [7:0]   o_frame_byte,
    input wire logic         o_last,
    input wire logic [11:0]  o_expected_len,
    input wire logic         o_param_error
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_byte)
            && $stable(o_last))
        else $error("result changed while stalled");

    // rejection is a lone, empty, final result
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_param_error |-> o_last && o_frame_byte == 8'h00
            && o_expected_len == 12'd0)
        else $error("malformed error result");

    // reply length only rides on the final byte
    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_expected_len == 12'd0 && !o_param_error)
        else $error("reply length before final byte");

    // any good frame expects at least six reply bytes
    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !o_param_error |-> o_expected_len >= 12'd6)
        else $error("reply length too short");

endmodule

bind modbus_rtu_request_framer mbrtu_checker u_chk (.*);

`default_nettype wire

[tb/mbrtu_frame_checker.sv]
`timescale 1ns / 100ps

module mbrtu_frame_checker
    import mbrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_slave,
    input  logic        i_is_write,
    input  logic [1:0]  i_area,
    input  logic [15:0] i_start_addr,
    input  logic [15:0] i_item_count,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last,
    input  logic [11:0] i_expected_len,
    input  logic        i_param_error,
    output int          o_pending,
    output int          o_errors
);

    localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DATA,
        SEQ_COIL
    } seq_mode_t;

    typedef struct {
        logic [7:0]  fbyte;
        logic        last;
        logic [11:0] rlen;
        logic        perr;
    } frame_result_t;

    frame_result_t frame_q[$];
    frame_result_t want;

    logic [15:0] crc_acc;
    seq_mode_t   seq_mode;
    logic [7:0]  bytes_left;
    logic [7:0]  tail_keep;
    logic [11:0] reply_bytes;
    int          err_count = 0;
    int          rx_index = 0;

    assign o_errors = err_count;

    task automatic report(input string msg);
        $display("%0t mbrtu_frame_checker: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic push_result(input logic [7:0] b, input logic last, input logic err);
        frame_result_t r;
        r.fbyte = b;
        r.last  = last;
        r.rlen  = (last && !err) ? reply_bytes : 12'd0;
        r.perr  = err;
        frame_q.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        crc_acc = crc_after(crc_acc, b);
        push_result(b, 1'b0, 1'b0);
    endtask

    task automatic clear_frame();
        crc_acc    = CRC_INIT;
        seq_mode   = SEQ_IDLE;
        bytes_left = 8'd0;
        tail_keep  = 8'hFF;
    endtask

    task automatic close_frame();
        push_result(crc_acc[7:0], 1'b0, 1'b0);
        push_result(crc_acc[15:8], 1'b1, 1'b0);
        clear_frame();
    endtask

    task automatic predict_header(input logic [7:0] slave, input logic wr,
                                  input logic [1:0] area, input logic [15:0] addr,
                                  input logic [15:0] cnt);
        logic       rej;
        logic [7:0] fc;
        int         cnt_v;
        int         nbytes;
        cnt_v  = cnt;
        nbytes = 0;
        fc     = 8'd0;
        rej    = (slave > SLAVE_MAX) || (cnt_v == 0) || (cnt_v > 8 * PAYLOAD_CAP);
        clear_frame();
        if (!rej) begin
            if (!wr) begin
                case (area)
                    AREA_COILS:    fc = FC_RD_COILS;
                    AREA_DISCRETE: fc = FC_RD_DISCRETE;
                    AREA_INPUT:    fc = FC_RD_INPUT;
                    default:       fc = FC_RD_HOLDING;
                endcase
            end else if (area == AREA_COILS) begin
                fc     = (cnt_v == 1) ? FC_WR_COIL : FC_WR_COILS;
                nbytes = (cnt_v + 7) / 8;
                if (fc == FC_WR_COILS && nbytes > PAYLOAD_CAP) begin
                    rej = 1'b1;
                end
            end else if (area == AREA_HOLDING) begin
                fc     = (cnt_v == 1) ? FC_WR_REG : FC_WR_REGS;
                nbytes = cnt_v * 2;
                if (fc == FC_WR_REGS && nbytes > PAYLOAD_CAP) begin
                    rej = 1'b1;
                end
            end else begin
                rej = 1'b1;
            end
        end
        if (rej) begin
            reply_bytes = 12'd0;
            push_result(8'd0, 1'b1, 1'b1);
        end else begin
            put_byte(slave);
            put_byte(fc);
            put_byte(addr[15:8]);
            put_byte(addr[7:0]);
            if (!wr) begin
                if (area == AREA_COILS || area == AREA_DISCRETE) begin
                    reply_bytes = 12'((cnt_v + 7) / 8 + 5);
                end else begin
                    reply_bytes = 12'(cnt_v * 2 + 5);
                end
                put_byte(cnt[15:8]);
                put_byte(cnt[7:0]);
                close_frame();
            end else begin
                reply_bytes = REPLY_WR_LEN;
                if (fc == FC_WR_COIL) begin
                    seq_mode   = SEQ_COIL;
                    bytes_left = 8'd1;
                end else if (fc == FC_WR_REG) begin
                    seq_mode   = SEQ_DATA;
                    bytes_left = 8'd2;
                end else begin
                    put_byte(cnt[15:8]);
                    put_byte(cnt[7:0]);
                    put_byte(8'(nbytes));
                    seq_mode   = SEQ_DATA;
                    bytes_left = 8'(nbytes);
                    if (fc == FC_WR_COILS && cnt[2:0] != 3'd0) begin
                        tail_keep = 8'((1 << cnt[2:0]) - 1);
                    end
                end
            end
        end
    endtask

    task automatic predict_payload(input logic [7:0] d);
        case (seq_mode)
            SEQ_COIL: begin
                put_byte(d[0] ? 8'hFF : 8'h00);
                put_byte(8'h00);
                close_frame();
            end
            SEQ_DATA: begin
                if (bytes_left <= 8'd1) begin
                    put_byte(d & tail_keep);
                    close_frame();
                end else begin
                    put_byte(d);
                    bytes_left = bytes_left - 8'd1;
                end
            end
            default: begin
                // byte outside a frame is dropped
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            reply_bytes = 12'd0;
            frame_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (!i_kind) begin
                    predict_header(i_slave, i_is_write, i_area, i_start_addr, i_item_count);
                end else begin
                    predict_payload(i_data_byte);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_q.size() == 0) begin
                    report($sformatf("result %0d with nothing expected: byte %02h last %0b",
                                     rx_index, i_frame_byte, i_last));
                end else begin
                    want = frame_q.pop_front();
                    if (i_frame_byte !== want.fbyte) begin
                        report($sformatf("result %0d frame_byte %02h, expected %02h",
                                         rx_index, i_frame_byte, want.fbyte));
                    end
                    if (i_last !== want.last) begin
                        report($sformatf("result %0d last %0b, expected %0b",
                                         rx_index, i_last, want.last));
                    end
                    if (i_expected_len !== want.rlen) begin
                        report($sformatf("result %0d expected_len %0d, expected %0d",
                                         rx_index, i_expected_len, want.rlen));
                    end
                    if (i_param_error !== want.perr) begin
                        report($sformatf("result %0d param_error %0b, expected %0b",
                                         rx_index, i_param_error, want.perr));
                    end
                end
                rx_index++;
            end
        end
        o_pending <= frame_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import mbrtu_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_kind = 1'b0;
    logic [7:0]  in_slave = 8'd0;
    logic        in_is_write = 1'b0;
    logic [1:0]  in_area = 2'd0;
    logic [15:0] in_start_addr = 16'd0;
    logic [15:0] in_item_count = 16'd0;
    logic [7:0]  in_data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_frame_byte;
    logic        out_last;
    logic [11:0] out_expected_len;
    logic        out_param_error;

    int pending;
    int errors;
    int tx_gap_pct = 0;
    int rx_gap_pct = 0;
    int items_sent = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    always #4 clk = ~clk;

    modbus_rtu_request_framer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_slave        (in_slave),
        .i_is_write     (in_is_write),
        .i_area         (in_area),
        .i_start_addr   (in_start_addr),
        .i_item_count   (in_item_count),
        .i_data_byte    (in_data_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_byte   (out_frame_byte),
        .o_last         (out_last),
        .o_expected_len (out_expected_len),
        .o_param_error  (out_param_error)
    );

    mbrtu_frame_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_slave        (in_slave),
        .i_is_write     (in_is_write),
        .i_area         (in_area),
        .i_start_addr   (in_start_addr),
        .i_item_count   (in_item_count),
        .i_data_byte    (in_data_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_frame_byte   (out_frame_byte),
        .i_last         (out_last),
        .i_expected_len (out_expected_len),
        .i_param_error  (out_param_error),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic drive_txn(input logic kind, input logic [7:0] slave, input logic wr,
                             input logic [1:0] area, input logic [15:0] addr,
                             input logic [15:0] cnt, input logic [7:0] data);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_kind       <= kind;
        in_slave      <= slave;
        in_is_write   <= wr;
        in_area       <= area;
        in_start_addr <= addr;
        in_item_count <= cnt;
        in_data_byte  <= data;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_header(input logic [7:0] slave, input logic wr, input logic [1:0] area,
                               input logic [15:0] addr, input logic [15:0] cnt);
        drive_txn(1'b0, slave, wr, area, addr, cnt, 8'($urandom));
        items_sent++;
    endtask

    task automatic send_data(input logic [7:0] d);
        drive_txn(1'b1, 8'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
                  16'($urandom), d);
        items_sent++;
    endtask

    task automatic random_request();
        int          pick;
        int          nbytes;
        int          keep;
        logic        wr;
        logic [1:0]  area;
        logic [15:0] cnt;
        logic [7:0]  slave;
        slave = 8'($urandom_range(SLAVE_MAX));
        pick  = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(4))
                0: send_header(8'($urandom_range(255, 248)), 1'($urandom), 2'($urandom),
                               16'($urandom), 16'($urandom_range(1, 20)));
                1: send_header(slave, 1'($urandom), 2'($urandom), 16'($urandom), 16'd0);
                2: send_header(slave, 1'($urandom), 2'($urandom), 16'($urandom),
                               16'($urandom_range(65535, 1921)));
                3: send_header(slave, 1'b1, 2'($urandom_range(2, 1)), 16'($urandom),
                               16'($urandom_range(65535, 1)));
                default: send_header(slave, 1'b1, AREA_HOLDING, 16'($urandom),
                                     16'($urandom_range(1920, 121)));
            endcase
        end else if (pick < 13) begin
            // stray data byte, dropped unless a frame is still open
            drive_txn(1'b1, 8'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom));
            items_sent++;
        end else begin
            wr = ($urandom_range(99) < 55);
            if (wr) begin
                area = $urandom_range(1) ? AREA_HOLDING : AREA_COILS;
            end else begin
                area = 2'($urandom);
            end
            if ($urandom_range(99) < 2) begin
                if (!wr) begin
                    cnt = 16'($urandom_range(1920, 1));
                end else if (area == AREA_COILS) begin
                    cnt = 16'd1920;
                end else begin
                    cnt = 16'd120;
                end
            end else if (area == AREA_COILS || area == AREA_DISCRETE) begin
                cnt = 16'($urandom_range(40, 1));
            end else begin
                cnt = 16'($urandom_range(12, 1));
            end
            if (!wr) begin
                nbytes = 0;
            end else if (area == AREA_COILS) begin
                nbytes = (cnt == 16'd1) ? 1 : (int'(cnt) + 7) / 8;
            end else begin
                nbytes = (cnt == 16'd1) ? 2 : int'(cnt) * 2;
            end
            keep = nbytes;
            if (pick < 20 && nbytes > 1) begin
                keep = $urandom_range(nbytes - 1, 0);
            end
            send_header(slave, wr, area, 16'($urandom), cnt);
            repeat (keep) send_data(8'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_pct = 22;
        rx_gap_pct <= 70;

        // reads of every area at the count limits, the holding read just past the upper one
        send_header(8'd0, 1'b0, AREA_COILS, 16'h0000, 16'd1);
        send_header(SLAVE_MAX, 1'b0, AREA_DISCRETE, 16'hFFFF, 16'd1920);
        send_header(8'd17, 1'b0, AREA_INPUT, 16'h5AA5, 16'd1920);
        send_header(8'd1, 1'b0, AREA_HOLDING, 16'h1234, 16'd1921);
        // rejected headers
        send_header(8'd248, 1'b0, AREA_HOLDING, 16'h0001, 16'd1);
        send_header(8'd255, 1'b0, AREA_COILS, 16'h0001, 16'd0);
        send_header(8'd3, 1'b1, AREA_DISCRETE, 16'h0010, 16'd4);
        send_header(8'd3, 1'b1, AREA_INPUT, 16'h0010, 16'd4);
        send_header(8'd3, 1'b1, AREA_HOLDING, 16'h0010, 16'd121);
        // data byte while idle
        drive_txn(1'b1, 8'd0, 1'b0, AREA_COILS, 16'd0, 16'd0, 8'hA5);
        items_sent++;
        // single coil on and off
        send_header(8'd9, 1'b1, AREA_COILS, 16'h00AC, 16'd1);
        send_data(8'h01);
        send_header(8'd9, 1'b1, AREA_COILS, 16'h00AC, 16'd1);
        send_data(8'hFE);
        // single register
        send_header(8'd10, 1'b1, AREA_HOLDING, 16'h0101, 16'd1);
        send_data(8'hAB);
        send_data(8'hCD);
        // coil block with a partial last byte
        send_header(8'd11, 1'b1, AREA_COILS, 16'h0013, 16'd9);
        send_data(8'hFF);
        send_data(8'hFF);
        // register block cut short by a new header
        send_header(8'd12, 1'b1, AREA_HOLDING, 16'h0001, 16'd2);
        send_data(8'h12);
        send_data(8'h34);
        send_header(8'd12, 1'b0, AREA_HOLDING, 16'h006B, 16'd125);
        // coil block with a whole last byte
        send_header(8'd13, 1'b1, AREA_COILS, 16'h8000, 16'd16);
        send_data(8'h5A);
        send_data(8'hC3);

        while (items_sent < 175) begin
            random_request();
        end

        tx_gap_pct = 70;
        rx_gap_pct <= 22;
        while (items_sent < 330) begin
            random_request();
        end

        tx_gap_pct = 0;
        rx_gap_pct <= 0;
        hold_req <= 1'b1;
        while (items_sent < 455) begin
            random_request();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/mbrtu_pkg.sv
rtl/mbrtu_front.sv
rtl/mbrtu_queue.sv
rtl/mbrtu_back.sv
rtl/modbus_rtu_request_framer.sv
rtl/mbrtu_checker.sv
tb/mbrtu_frame_checker.sv
tb/tb_top.sv
